// File: design/touch_dpad_region_mapper_assert.svh
// assertion macros for the touch dpad region mapper
// no dependencies; included by the top level, which checks its own logic
`ifndef TOUCH_DPAD_REGION_MAPPER_ASSERT_SVH
`define TOUCH_DPAD_REGION_MAPPER_ASSERT_SVH

// same-cycle implication
`define TDRM_ASSERT_HOLDS(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tdrm: same-cycle property violated");

// next-cycle implication
`define TDRM_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tdrm: next-cycle property violated");

`endif

// File: design/tdrm_pkg.sv
// shared types, constants and tables of the touch dpad region mapper
// no dependencies; used by tdrm_if, tdrm_cordic and the top level
package tdrm_pkg;

    localparam int DEF_MAX_POINTS       = 16;
    localparam int DEF_COORD_BITS       = 16;
    localparam int DEF_ANGLE_ITERATIONS = 16;

    localparam int CFG_W        = 64;
    localparam int CFG_IDX_W    = 3;
    localparam int FIELD_STRIDE = 16;
    localparam int PIXEL_W      = 16;
    localparam int DZ_RADIUS_W  = 15;
    localparam int ROT_W        = 16;
    localparam int ROT_SHIFT    = 12;
    localparam int MUL_B_W      = 16;
    localparam int DZ_FRAC_BITS = 28;
    localparam int ANGLE_W      = 30;
    localparam int ATAN_IDX_W   = 5;
    localparam int ATAN_W       = 24;
    localparam int SUM_W        = 6;
    localparam int AXIS_W       = 2;
    localparam int SECT_W       = 3;
    localparam int DEG_FRAC     = 18;
    localparam int SECT_N_W     = 12;
    localparam int RECIP_W      = 11;
    localparam int RECIP_SHIFT  = 16;

    localparam logic [ANGLE_W-1:0] DEG90      = ANGLE_W'(23592960);
    localparam logic [ANGLE_W-1:0] DEG45_HALF = ANGLE_W'(5898240);
    localparam logic [RECIP_W-1:0] RECIP_45   = RECIP_W'(1457);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DPAD_RECT       = 3'd0,
        REG_FIRE_LEFT_RECT  = 3'd1,
        REG_FIRE_RIGHT_RECT = 3'd2,
        REG_MENU_RECT       = 3'd3,
        REG_DZ_RADIUS       = 3'd4,
        REG_ROTATION        = 3'd5
    } cfg_reg_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_CMP,
        S_ANGLE,
        S_SECTOR,
        S_FINISH
    } state_t;

    typedef enum logic [2:0] {
        OP_AX,
        OP_BY,
        OP_P,
        OP_DZP,
        OP_SQA,
        OP_SQB,
        OP_DD
    } op_t;

    typedef struct packed {
        logic start;
    } cordic_ctl_t;

    typedef struct packed {
        logic busy;
    } cordic_stat_t;

    function automatic logic [ATAN_W-1:0] atan_entry(input logic [ATAN_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] val;
        unique case (idx)
            5'd0:    val = 24'd11796480;
            5'd1:    val = 24'd6963869;
            5'd2:    val = 24'd3679517;
            5'd3:    val = 24'd1867780;
            5'd4:    val = 24'd937515;
            5'd5:    val = 24'd469214;
            5'd6:    val = 24'd234664;
            5'd7:    val = 24'd117339;
            5'd8:    val = 24'd58671;
            5'd9:    val = 24'd29335;
            5'd10:   val = 24'd14668;
            5'd11:   val = 24'd7334;
            5'd12:   val = 24'd3667;
            5'd13:   val = 24'd1833;
            5'd14:   val = 24'd917;
            5'd15:   val = 24'd458;
            5'd16:   val = 24'd229;
            5'd17:   val = 24'd115;
            5'd18:   val = 24'd57;
            5'd19:   val = 24'd29;
            5'd20:   val = 24'd14;
            5'd21:   val = 24'd7;
            5'd22:   val = 24'd4;
            5'd23:   val = 24'd2;
            default: val = '0;
        endcase
        return val;
    endfunction

    function automatic logic signed [AXIS_W-1:0] dir_x(input logic [SECT_W-1:0] sec);
        logic signed [AXIS_W-1:0] d;
        unique case (sec)
            3'd0, 3'd1, 3'd7: d = 2'sd1;
            3'd3, 3'd4, 3'd5: d = -2'sd1;
            default:          d = 2'sd0;
        endcase
        return d;
    endfunction

    function automatic logic signed [AXIS_W-1:0] dir_y(input logic [SECT_W-1:0] sec);
        logic signed [AXIS_W-1:0] d;
        unique case (sec)
            3'd1, 3'd2, 3'd3: d = 2'sd1;
            3'd5, 3'd6, 3'd7: d = -2'sd1;
            default:          d = 2'sd0;
        endcase
        return d;
    endfunction

    function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] s,
                                                        input logic signed [AXIS_W-1:0] d);
        logic signed [SUM_W:0] t;
        t = (SUM_W+1)'(s) + (SUM_W+1)'(d);
        return (t[SUM_W] != t[SUM_W-1]) ? s : t[SUM_W-1:0];
    endfunction

    function automatic logic signed [AXIS_W-1:0] clamp1(input logic signed [SUM_W-1:0] s);
        logic signed [AXIS_W-1:0] c;
        if (s == '0)
            c = 2'sd0;
        else if (s[SUM_W-1])
            c = -2'sd1;
        else
            c = 2'sd1;
        return c;
    endfunction

endpackage

// File: design/tdrm_if.sv
// touch point and result channel interfaces, valid/ready handshake
// depends on tdrm_pkg for the field widths
interface tdrm_touch_if import tdrm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] touch_x;
    logic [PIXEL_W-1:0] touch_y;
    logic               point_present;
    logic               frame_end;

    modport source (output valid, touch_x, touch_y, point_present, frame_end, input ready);
    modport sink (input valid, touch_x, touch_y, point_present, frame_end, output ready);
endinterface

interface tdrm_result_if import tdrm_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [AXIS_W-1:0]  axis_horizontal;
    logic signed [AXIS_W-1:0]  axis_vertical;
    logic                      fire_pressed;
    logic                      menu_pressed;
    logic                      horizontal_changed;
    logic                      vertical_changed;
    logic                      fire_changed;

    modport source (output valid, axis_horizontal, axis_vertical, fire_pressed, menu_pressed,
                    horizontal_changed, vertical_changed, fire_changed, input ready);
    modport sink (input valid, axis_horizontal, axis_vertical, fire_pressed, menu_pressed,
                  horizontal_changed, vertical_changed, fire_changed, output ready);
endinterface

// File: design/tdrm_mul.sv
// shared unsigned multiplier with registered product
// no package dependencies; sequenced by the top level
module tdrm_mul #(
    parameter int A_W = 47,
    parameter int B_W = 16
) (
    input  logic               clk,
    input  logic               en,
    input  logic [A_W-1:0]     a,
    input  logic [B_W-1:0]     b,
    output logic [A_W+B_W-1:0] prod_reg
);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
        end
    end

endmodule

// File: design/tdrm_cordic.sv
// iterative vectoring cordic, one micro-rotation per cycle, angle in 1/262144 degree
// depends on tdrm_pkg for the arctangent table and control structs
module tdrm_cordic import tdrm_pkg::*; #(
    parameter int CW    = 36,
    parameter int ITERS = DEF_ANGLE_ITERATIONS
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  cordic_ctl_t                ctl,
    input  logic signed [CW-1:0]       x_in,
    input  logic signed [CW-1:0]       y_in,
    output logic signed [ANGLE_W-1:0]  z_reg,
    output cordic_stat_t               stat
);

    localparam int IT_W = (ITERS > 1) ? $clog2(ITERS) : 1;

    logic                      busy_reg;
    logic [IT_W-1:0]           it_reg;
    logic signed [CW-1:0]      x_reg;
    logic signed [CW-1:0]      y_reg;
    logic signed [CW-1:0]      x_sh;
    logic signed [CW-1:0]      y_sh;
    logic signed [ANGLE_W-1:0] at_s;

    assign x_sh = x_reg >>> it_reg;
    assign y_sh = y_reg >>> it_reg;
    assign at_s = ANGLE_W'(atan_entry(ATAN_IDX_W'(it_reg)));
    assign stat.busy = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            it_reg   <= '0;
        end
        else if (ctl.start)
        begin
            busy_reg <= !(x_in == '0 && y_in == '0);
            it_reg   <= '0;
        end
        else if (busy_reg)
        begin
            busy_reg <= (it_reg != IT_W'(ITERS - 1));
            it_reg   <= it_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            if (x_in == '0 && y_in == '0)
            begin
                x_reg <= x_in;
                y_reg <= y_in;
                z_reg <= '0;
            end
            else if (!x_in[CW-1])
            begin
                x_reg <= x_in;
                y_reg <= y_in;
                z_reg <= '0;
            end
            else if (!y_in[CW-1])
            begin
                x_reg <= y_in;
                y_reg <= -x_in;
                z_reg <= DEG90;
            end
            else
            begin
                x_reg <= -y_in;
                y_reg <= x_in;
                z_reg <= -DEG90;
            end
        end
        else if (busy_reg)
        begin
            if (y_reg > 0)
            begin
                x_reg <= x_reg + y_sh;
                y_reg <= y_reg - x_sh;
                z_reg <= z_reg + at_s;
            end
            else
            begin
                x_reg <= x_reg - y_sh;
                y_reg <= y_reg + x_sh;
                z_reg <= z_reg - at_s;
            end
        end
    end

endmodule

// File: design/touch_dpad_region_mapper.sv
// touch_dpad_region_mapper: top level with sequencer and point datapath
// an empty item, a point off the dpad or past the point limit is taken in the idle state;
// a dpad point runs multiply/accumulate steps and a dead-zone compare, then, outside the
// dead zone, the cordic angle step (done at once at the exact centre) and the sector step;
// frame end waits in the finish state while the result register is held; reset clears
// control, config, frame and valid state; depends on tdrm_pkg, tdrm_if, tdrm_mul, tdrm_cordic
module touch_dpad_region_mapper import tdrm_pkg::*; #(
    parameter int MAX_POINTS       = DEF_MAX_POINTS,
    parameter int COORD_BITS       = DEF_COORD_BITS,
    parameter int ANGLE_ITERATIONS = DEF_ANGLE_ITERATIONS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    tdrm_touch_if.sink           touch,
    tdrm_result_if.source        result,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

`include "touch_dpad_region_mapper_assert.svh"

    localparam int CB        = COORD_BITS;
    localparam int MAG_W     = 2 * CB;
    localparam int MA        = MAG_W + DZ_RADIUS_W;
    localparam int PW        = MA + MUL_B_W;
    localparam int SQ_CHUNKS = (MAG_W + MUL_B_W - 1) / MUL_B_W;
    localparam int DZ_CHUNKS = (MA + MUL_B_W - 1) / MUL_B_W;
    localparam int CHK_W     = $clog2(DZ_CHUNKS);
    localparam int LW        = 2 * MAG_W + 1;
    localparam int RW        = 2 * MA;
    localparam int CW        = MAG_W + 4;
    localparam int U_W       = CB + 3;
    localparam int CNT_W     = $clog2(MAX_POINTS + 1);

    function automatic logic rect_hit(input logic [CFG_W-1:0] rect,
                                      input logic [CB-1:0] px, input logic [CB-1:0] py);
        logic [CB-1:0] l;
        logic [CB-1:0] t;
        logic [CB-1:0] r;
        logic [CB-1:0] b;
        l = rect[0 +: CB];
        t = rect[FIELD_STRIDE +: CB];
        r = rect[2*FIELD_STRIDE +: CB];
        b = rect[3*FIELD_STRIDE +: CB];
        return (r > l) && (b > t) && (px >= l) && (px <= r) && (py >= t) && (py <= b);
    endfunction

    // configuration
    logic [CFG_W-1:0]        dpad_rect_reg;
    logic [CFG_W-1:0]        fire_left_rect_reg;
    logic [CFG_W-1:0]        fire_right_rect_reg;
    logic [CFG_W-1:0]        menu_rect_reg;
    logic [DZ_RADIUS_W-1:0]  dz_radius_reg;
    logic signed [ROT_W-1:0] rotation_reg;

    // control
    state_t                  state_reg;
    state_t                  state_next;
    op_t                     op_reg;
    logic [CHK_W-1:0]        chunk_reg;
    logic [CNT_W-1:0]        point_count_reg;
    logic                    fe_reg;

    // frame state
    logic signed [SUM_W-1:0]  sum_h_reg;
    logic signed [SUM_W-1:0]  sum_v_reg;
    logic                     fire_seen_reg;
    logic                     menu_seen_reg;
    logic signed [AXIS_W-1:0] prev_h_reg;
    logic signed [AXIS_W-1:0] prev_v_reg;
    logic                     prev_fire_reg;
    logic                     prev_menu_reg;

    // point datapath
    logic [CB-1:0]           u_mag_reg;
    logic                    u_neg_reg;
    logic [CB-1:0]           v_mag_reg;
    logic                    v_neg_reg;
    logic [CB-1:0]           w_reg;
    logic [CB-1:0]           h_reg;
    logic [MAG_W-1:0]        aa_reg;
    logic [MAG_W-1:0]        bb_reg;
    logic [MAG_W-1:0]        p_reg;
    logic [MA-1:0]           dzp_reg;
    logic [LW-1:0]           acc_l_reg;
    logic [RW-1:0]           acc_r_reg;

    // result register
    logic                     out_valid_reg;
    logic signed [AXIS_W-1:0] out_h_reg;
    logic signed [AXIS_W-1:0] out_v_reg;
    logic                     out_fire_reg;
    logic                     out_menu_reg;
    logic                     out_hc_reg;
    logic                     out_vc_reg;
    logic                     out_fc_reg;

    logic [CB-1:0]           px;
    logic [CB-1:0]           py;
    logic [CB-1:0]           dl;
    logic [CB-1:0]           dt;
    logic [CB-1:0]           dr;
    logic [CB-1:0]           db;
    logic [U_W-1:0]          u_full;
    logic [U_W-1:0]          v_full;
    logic                    accept;
    logic                    take;
    logic                    dpad_hit;
    logic                    touch_ready;
    logic                    mul_en;
    logic                    out_load;
    logic                    slot_free;
    logic                    dead;
    logic [MA-1:0]           mul_a;
    logic [MUL_B_W-1:0]      mul_b;
    logic [PW-1:0]           prod_reg;
    logic [SQ_CHUNKS*MUL_B_W-1:0] aa_pad;
    logic [SQ_CHUNKS*MUL_B_W-1:0] bb_pad;
    logic [DZ_CHUNKS*MUL_B_W-1:0] dzp_pad;
    logic signed [CW-1:0]    cx_in;
    logic signed [CW-1:0]    cy_in;
    cordic_ctl_t             cordic_ctl;
    cordic_stat_t            cordic_stat;
    logic signed [ANGLE_W-1:0] cz;
    logic signed [ANGLE_W-1:0] rot_ext;
    logic signed [ANGLE_W-1:0] zf;
    logic [ANGLE_W-1:0]      zmag;
    logic [ANGLE_W-1:0]      zround;
    logic [SECT_N_W-1:0]     sect_n;
    logic [SECT_N_W+RECIP_W-1:0] sect_prod;
    logic [SECT_W-1:0]       q3;
    logic [SECT_W-1:0]       sector;

    assign px = touch.touch_x[CB-1:0];
    assign py = touch.touch_y[CB-1:0];
    assign dl = dpad_rect_reg[0 +: CB];
    assign dt = dpad_rect_reg[FIELD_STRIDE +: CB];
    assign dr = dpad_rect_reg[2*FIELD_STRIDE +: CB];
    assign db = dpad_rect_reg[3*FIELD_STRIDE +: CB];
    assign u_full = U_W'({px, 1'b0}) - U_W'(dl) - U_W'(dr);
    assign v_full = U_W'({py, 1'b0}) - U_W'(dt) - U_W'(db);

    assign accept   = touch.valid && touch_ready;
    assign take     = touch.point_present && (point_count_reg < CNT_W'(MAX_POINTS));
    assign dpad_hit = rect_hit(dpad_rect_reg, px, py);
    assign slot_free = !out_valid_reg || result.ready;

    assign aa_pad  = (SQ_CHUNKS*MUL_B_W)'(aa_reg);
    assign bb_pad  = (SQ_CHUNKS*MUL_B_W)'(bb_reg);
    assign dzp_pad = (DZ_CHUNKS*MUL_B_W)'(dzp_reg);
    assign dead    = RW'({acc_l_reg, DZ_FRAC_BITS'(0)}) < acc_r_reg;

    assign cx_in = u_neg_reg ? -CW'(aa_reg) : CW'(aa_reg);
    assign cy_in = v_neg_reg ? -CW'(bb_reg) : CW'(bb_reg);

    assign rot_ext   = ANGLE_W'(rotation_reg);
    assign zf        = cz - (rot_ext <<< ROT_SHIFT);
    assign zmag      = zf[ANGLE_W-1] ? ANGLE_W'(-zf) : ANGLE_W'(zf);
    assign zround    = zmag + DEG45_HALF;
    assign sect_n    = SECT_N_W'(zround >> DEG_FRAC);
    assign sect_prod = (SECT_N_W+RECIP_W)'(sect_n) * (SECT_N_W+RECIP_W)'(RECIP_45);
    assign q3        = sect_prod[RECIP_SHIFT +: SECT_W];
    assign sector    = zf[ANGLE_W-1] ? SECT_W'(3'd0 - q3) : q3;

    // multiplier operand select
    always_comb
    begin
        unique case (op_reg)
            OP_AX:
            begin
                mul_a = MA'(u_mag_reg);
                mul_b = MUL_B_W'(h_reg);
            end
            OP_BY:
            begin
                mul_a = MA'(v_mag_reg);
                mul_b = MUL_B_W'(w_reg);
            end
            OP_P:
            begin
                mul_a = MA'(w_reg);
                mul_b = MUL_B_W'(h_reg);
            end
            OP_DZP:
            begin
                mul_a = MA'(p_reg);
                mul_b = MUL_B_W'(dz_radius_reg);
            end
            OP_SQA:
            begin
                mul_a = MA'(aa_reg);
                mul_b = aa_pad[chunk_reg*MUL_B_W +: MUL_B_W];
            end
            OP_SQB:
            begin
                mul_a = MA'(bb_reg);
                mul_b = bb_pad[chunk_reg*MUL_B_W +: MUL_B_W];
            end
            OP_DD:
            begin
                mul_a = dzp_reg;
                mul_b = dzp_pad[chunk_reg*MUL_B_W +: MUL_B_W];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    tdrm_mul #(
        .A_W (MA),
        .B_W (MUL_B_W)
    ) u_mul (
        .clk      (clk),
        .en       (mul_en),
        .a        (mul_a),
        .b        (mul_b),
        .prod_reg (prod_reg)
    );

    tdrm_cordic #(
        .CW    (CW),
        .ITERS (ANGLE_ITERATIONS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (cordic_ctl),
        .x_in  (cx_in),
        .y_in  (cy_in),
        .z_reg (cz),
        .stat  (cordic_stat)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (touch.valid)
                begin
                    if (take && dpad_hit)
                        state_next = S_MUL;
                    else if (touch.frame_end)
                        state_next = S_FINISH;
                end
            end
            S_MUL:
                state_next = S_ACC;
            S_ACC:
            begin
                if (op_reg == OP_DD && chunk_reg == '0)
                    state_next = S_CMP;
                else
                    state_next = S_MUL;
            end
            S_CMP:
            begin
                if (!dead)
                    state_next = S_ANGLE;
                else
                    state_next = fe_reg ? S_FINISH : S_IDLE;
            end
            S_ANGLE:
            begin
                if (!cordic_stat.busy)
                    state_next = S_SECTOR;
            end
            S_SECTOR:
                state_next = fe_reg ? S_FINISH : S_IDLE;
            S_FINISH:
            begin
                if (slot_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        touch_ready      = 1'b0;
        mul_en           = 1'b0;
        out_load         = 1'b0;
        cordic_ctl.start = 1'b0;
        unique case (state_reg)
            S_IDLE:   touch_ready = 1'b1;
            S_MUL:    mul_en = 1'b1;
            S_CMP:    cordic_ctl.start = !dead;
            S_FINISH: out_load = slot_free;
            default:  ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dpad_rect_reg       <= '0;
            fire_left_rect_reg  <= '0;
            fire_right_rect_reg <= '0;
            menu_rect_reg       <= '0;
            dz_radius_reg       <= '0;
            rotation_reg        <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DPAD_RECT:       dpad_rect_reg       <= cfg_data;
                REG_FIRE_LEFT_RECT:  fire_left_rect_reg  <= cfg_data;
                REG_FIRE_RIGHT_RECT: fire_right_rect_reg <= cfg_data;
                REG_MENU_RECT:       menu_rect_reg       <= cfg_data;
                REG_DZ_RADIUS:       dz_radius_reg       <= cfg_data[DZ_RADIUS_W-1:0];
                REG_ROTATION:        rotation_reg        <= cfg_data[ROT_W-1:0];
                default:             ;
            endcase
        end
    end

    // frame state and results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= '0;
            fe_reg          <= 1'b0;
            sum_h_reg       <= '0;
            sum_v_reg       <= '0;
            fire_seen_reg   <= 1'b0;
            menu_seen_reg   <= 1'b0;
            prev_h_reg      <= '0;
            prev_v_reg      <= '0;
            prev_fire_reg   <= 1'b0;
            prev_menu_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
            if (accept)
            begin
                fe_reg <= touch.frame_end;
                if (take)
                begin
                    point_count_reg <= point_count_reg + 1'b1;
                    if (rect_hit(fire_left_rect_reg, px, py) ||
                        rect_hit(fire_right_rect_reg, px, py))
                        fire_seen_reg <= 1'b1;
                    if (rect_hit(menu_rect_reg, px, py))
                        menu_seen_reg <= 1'b1;
                end
            end
            if (state_reg == S_SECTOR)
            begin
                sum_h_reg <= sat_add(sum_h_reg, dir_x(sector));
                sum_v_reg <= sat_add(sum_v_reg, dir_y(sector));
            end
            if (out_load)
            begin
                prev_h_reg      <= clamp1(sum_h_reg);
                prev_v_reg      <= clamp1(sum_v_reg);
                prev_fire_reg   <= fire_seen_reg;
                prev_menu_reg   <= menu_seen_reg;
                sum_h_reg       <= '0;
                sum_v_reg       <= '0;
                fire_seen_reg   <= 1'b0;
                menu_seen_reg   <= 1'b0;
                point_count_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_h_reg    <= clamp1(sum_h_reg);
            out_v_reg    <= clamp1(sum_v_reg);
            out_fire_reg <= fire_seen_reg;
            out_menu_reg <= menu_seen_reg;
            out_hc_reg   <= clamp1(sum_h_reg) != prev_h_reg;
            out_vc_reg   <= clamp1(sum_v_reg) != prev_v_reg;
            out_fc_reg   <= fire_seen_reg != prev_fire_reg;
        end
    end

    // point datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg    <= OP_AX;
            chunk_reg <= '0;
        end
        else if (accept)
        begin
            op_reg    <= OP_AX;
            chunk_reg <= '0;
        end
        else if (state_reg == S_ACC)
        begin
            unique case (op_reg)
                OP_AX:  op_reg <= OP_BY;
                OP_BY:  op_reg <= OP_P;
                OP_P:   op_reg <= OP_DZP;
                OP_DZP:
                begin
                    op_reg    <= OP_SQA;
                    chunk_reg <= CHK_W'(SQ_CHUNKS - 1);
                end
                OP_SQA: op_reg <= OP_SQB;
                OP_SQB:
                begin
                    if (chunk_reg == '0)
                    begin
                        op_reg    <= OP_DD;
                        chunk_reg <= CHK_W'(DZ_CHUNKS - 1);
                    end
                    else
                    begin
                        op_reg    <= OP_SQA;
                        chunk_reg <= chunk_reg - 1'b1;
                    end
                end
                OP_DD:
                begin
                    if (chunk_reg != '0)
                        chunk_reg <= chunk_reg - 1'b1;
                end
                default: op_reg <= OP_AX;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            u_neg_reg <= u_full[U_W-1];
            u_mag_reg <= u_full[U_W-1] ? CB'(-u_full) : CB'(u_full);
            v_neg_reg <= v_full[U_W-1];
            v_mag_reg <= v_full[U_W-1] ? CB'(-v_full) : CB'(v_full);
            w_reg     <= dr - dl;
            h_reg     <= db - dt;
        end
        if (state_reg == S_ACC)
        begin
            unique case (op_reg)
                OP_AX:  aa_reg  <= prod_reg[MAG_W-1:0];
                OP_BY:  bb_reg  <= prod_reg[MAG_W-1:0];
                OP_P:   p_reg   <= prod_reg[MAG_W-1:0];
                OP_DZP:
                begin
                    dzp_reg   <= prod_reg[MA-1:0];
                    acc_l_reg <= '0;
                    acc_r_reg <= '0;
                end
                OP_SQA: acc_l_reg <= LW'({acc_l_reg, MUL_B_W'(0)}) + LW'(prod_reg);
                OP_SQB: acc_l_reg <= acc_l_reg + LW'(prod_reg);
                OP_DD:  acc_r_reg <= RW'({acc_r_reg, MUL_B_W'(0)}) + RW'(prod_reg);
                default: ;
            endcase
        end
    end

    assign touch.ready = touch_ready;

    assign result.valid              = out_valid_reg;
    assign result.axis_horizontal    = out_h_reg;
    assign result.axis_vertical      = out_v_reg;
    assign result.fire_pressed       = out_fire_reg;
    assign result.menu_pressed       = out_menu_reg;
    assign result.horizontal_changed = out_hc_reg;
    assign result.vertical_changed   = out_vc_reg;
    assign result.fire_changed       = out_fc_reg;

    `TDRM_ASSERT_HOLDS(a_count_bound, clk, rst_n, 1'b1, point_count_reg <= CNT_W'(MAX_POINTS))
    `TDRM_ASSERT_NEXT(a_finish_clears, clk, rst_n, out_load, out_valid_reg && point_count_reg == '0 && !fire_seen_reg && !menu_seen_reg)
    `TDRM_ASSERT_HOLDS(a_sector_after_angle, clk, rst_n, state_reg == S_SECTOR, !cordic_stat.busy)
    `TDRM_ASSERT_NEXT(a_frame_end_busy, clk, rst_n, accept && touch.frame_end, state_reg != S_IDLE)

endmodule
